// File: hdl/ppc_cvt_pkg.sv
// Shared types, opcode and extended-opcode codes for the constant-value tracker.
// No dependencies; the fold logic, the top level and the testbench refer to this package.
package ppc_cvt_pkg;

    localparam int unsigned NUM_GPRS   = 32;
    localparam int unsigned GPR_W      = 32;
    localparam int unsigned GPR_IDX_W  = 5;
    localparam int unsigned S_TDATA_W  = 64;
    localparam int unsigned S_TUSER_W  = 3;
    localparam int unsigned M_TDATA_W  = 48;

    localparam logic [GPR_W-1:0] ALL_ONES = 32'hFFFF_FFFF;

    localparam logic [5:0] OP_ADDI  = 6'd14;
    localparam logic [5:0] OP_ADDIS = 6'd15;
    localparam logic [5:0] OP_ORI   = 6'd24;
    localparam logic [5:0] OP_ORIS  = 6'd25;
    localparam logic [5:0] OP_XORI  = 6'd26;
    localparam logic [5:0] OP_XORIS = 6'd27;
    localparam logic [5:0] OP_ANDI  = 6'd28;
    localparam logic [5:0] OP_ANDIS = 6'd29;
    localparam logic [5:0] OP_EXT   = 6'd31;

    localparam logic [9:0] XO_ADDC  = 10'd10;
    localparam logic [9:0] XO_ADD   = 10'd266;
    localparam logic [9:0] XO_ADDCO = 10'd522;
    localparam logic [9:0] XO_ADDO  = 10'd778;
    localparam logic [9:0] XO_AND   = 10'd28;
    localparam logic [9:0] XO_ANDC  = 10'd60;
    localparam logic [9:0] XO_NOR   = 10'd124;
    localparam logic [9:0] XO_EQV   = 10'd284;
    localparam logic [9:0] XO_XOR   = 10'd316;
    localparam logic [9:0] XO_ORC   = 10'd412;
    localparam logic [9:0] XO_OR    = 10'd444;
    localparam logic [9:0] XO_NAND  = 10'd476;

    typedef struct packed {
        logic                 done;
        logic                 wr;
        logic [GPR_IDX_W-1:0] rd;
        logic [GPR_W-1:0]     val;
        logic                 rc;
        logic                 cav;
        logic                 ca;
        logic                 ovv;
        logic                 ov;
    } fold_t;

endpackage

// File: hdl/ppc_cvt_ram.sv
// Generic register-file memory: one write port, two read ports with registered read data.
// No dependencies.
module ppc_cvt_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_a_reg;
    logic [WIDTH-1:0] rd_b_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_a_reg <= mem_reg[rd_addr_a];
            rd_b_reg <= mem_reg[rd_addr_b];
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

// File: hdl/ppc_cvt_fold.sv
// Combinational folding of one instruction against the known register values.
// Depends on ppc_cvt_pkg for the opcode codes and the fold_t result type.
module ppc_cvt_fold (
    input  logic [31:0]                     instr_word,
    input  logic                            d_form_flag,
    input  logic                            sets_carry_flag,
    input  logic                            sets_overflow_flag,
    input  logic [ppc_cvt_pkg::NUM_GPRS-1:0] known_mask,
    input  logic [ppc_cvt_pkg::GPR_W-1:0]    val_a,
    input  logic [ppc_cvt_pkg::GPR_W-1:0]    val_b,
    output ppc_cvt_pkg::fold_t              result
);

    logic [5:0]  op;
    logic [4:0]  rs;
    logic [4:0]  ra;
    logic [4:0]  rb;
    logic [15:0] imm;
    logic [9:0]  sub;
    logic        rc;
    logic [31:0] k_add;
    logic [31:0] k_log;
    logic [32:0] sum;
    logic        is_and;
    ppc_cvt_pkg::fold_t res;

    function automatic ppc_cvt_pkg::fold_t write_res(input logic [4:0] rd,
                                                     input logic [31:0] val,
                                                     input logic rcb);
        ppc_cvt_pkg::fold_t f;
        f      = '0;
        f.done = 1'b1;
        f.wr   = 1'b1;
        f.rd   = rd;
        f.val  = val;
        f.rc   = rcb;
        return f;
    endfunction

    function automatic ppc_cvt_pkg::fold_t one_known(input logic [9:0] xo,
                                                     input logic [4:0] rd,
                                                     input logic rcb,
                                                     input logic [31:0] v,
                                                     input logic is_b);
        ppc_cvt_pkg::fold_t f;
        logic [31:0] vi;
        f  = '0;
        vi = is_b ? ~v : v;
        case (xo)
            ppc_cvt_pkg::XO_ANDC: if (vi == '0) f = write_res(rd, '0, rcb);
            ppc_cvt_pkg::XO_AND:  if (v == '0) f = write_res(rd, '0, rcb);
            ppc_cvt_pkg::XO_NOR: begin
                if (v == ppc_cvt_pkg::ALL_ONES) f = write_res(rd, '0, rcb);
            end
            ppc_cvt_pkg::XO_ORC: begin
                if (vi == ppc_cvt_pkg::ALL_ONES) begin
                    f = write_res(rd, ppc_cvt_pkg::ALL_ONES, rcb);
                end
            end
            ppc_cvt_pkg::XO_OR: begin
                if (v == ppc_cvt_pkg::ALL_ONES) begin
                    f = write_res(rd, ppc_cvt_pkg::ALL_ONES, rcb);
                end
            end
            ppc_cvt_pkg::XO_NAND: begin
                if (v == '0) f = write_res(rd, ppc_cvt_pkg::ALL_ONES, rcb);
            end
            default: f = '0;
        endcase
        return f;
    endfunction

    function automatic ppc_cvt_pkg::fold_t same_regs(input logic [9:0] xo,
                                                     input logic [4:0] rd,
                                                     input logic rcb);
        ppc_cvt_pkg::fold_t f;
        f = '0;
        case (xo) inside
            ppc_cvt_pkg::XO_ANDC, ppc_cvt_pkg::XO_XOR: f = write_res(rd, '0, rcb);
            ppc_cvt_pkg::XO_EQV, ppc_cvt_pkg::XO_ORC: begin
                f = write_res(rd, ppc_cvt_pkg::ALL_ONES, rcb);
            end
            default: f = '0;
        endcase
        return f;
    endfunction

    assign op     = instr_word[31:26];
    assign rs     = instr_word[25:21];
    assign ra     = instr_word[20:16];
    assign rb     = instr_word[15:11];
    assign imm    = instr_word[15:0];
    assign sub    = instr_word[10:1];
    assign rc     = instr_word[0];
    assign k_add  = op[0] ? {imm, 16'h0000} : {{16{imm[15]}}, imm};
    assign k_log  = op[0] ? {imm, 16'h0000} : {16'h0000, imm};
    assign sum    = {1'b0, val_a} + {1'b0, val_b};
    assign is_and = (op == ppc_cvt_pkg::OP_ANDI) || (op == ppc_cvt_pkg::OP_ANDIS);

    always_comb begin
        res = '0;
        case (op) inside
            ppc_cvt_pkg::OP_ADDI, ppc_cvt_pkg::OP_ADDIS: begin
                if (ra == '0) begin
                    res = write_res(rs, k_add, 1'b0);
                end else if (known_mask[ra]) begin
                    res = write_res(rs, val_a + k_add, 1'b0);
                end
            end
            ppc_cvt_pkg::OP_ORI, ppc_cvt_pkg::OP_ORIS, ppc_cvt_pkg::OP_XORI,
            ppc_cvt_pkg::OP_XORIS, ppc_cvt_pkg::OP_ANDI, ppc_cvt_pkg::OP_ANDIS: begin
                if (imm == '0 && !is_and && ra == rs) begin
                    res.done = 1'b1;
                end else if (known_mask[rs]) begin
                    if (op == ppc_cvt_pkg::OP_ORI || op == ppc_cvt_pkg::OP_ORIS) begin
                        res = write_res(ra, val_a | k_log, 1'b0);
                    end else if (op == ppc_cvt_pkg::OP_XORI || op == ppc_cvt_pkg::OP_XORIS) begin
                        res = write_res(ra, val_a ^ k_log, 1'b0);
                    end else begin
                        res = write_res(ra, val_a & k_log, 1'b1);
                    end
                end
            end
            ppc_cvt_pkg::OP_EXT: begin
                if (d_form_flag) begin
                    if (known_mask[ra] && known_mask[rb] &&
                        (sub == ppc_cvt_pkg::XO_ADDC || sub == ppc_cvt_pkg::XO_ADDCO ||
                         sub == ppc_cvt_pkg::XO_ADD || sub == ppc_cvt_pkg::XO_ADDO)) begin
                        res = write_res(rs, sum[31:0], rc);
                        if (sets_carry_flag) begin
                            res.cav = 1'b1;
                            res.ca  = sum[32];
                        end
                        if (sets_overflow_flag) begin
                            res.ovv = 1'b1;
                            res.ov  = ~(val_a[31] ^ val_b[31]) & (val_a[31] ^ sum[31]);
                        end
                    end
                end else if (known_mask[rs] && known_mask[rb]) begin
                    case (sub)
                        ppc_cvt_pkg::XO_AND:  res = write_res(ra, val_a & val_b, rc);
                        ppc_cvt_pkg::XO_ANDC: res = write_res(ra, val_a & ~val_b, rc);
                        ppc_cvt_pkg::XO_NOR:  res = write_res(ra, ~(val_a | val_b), rc);
                        ppc_cvt_pkg::XO_EQV:  res = write_res(ra, ~(val_a ^ val_b), rc);
                        ppc_cvt_pkg::XO_XOR:  res = write_res(ra, val_a ^ val_b, rc);
                        ppc_cvt_pkg::XO_ORC:  res = write_res(ra, val_a | ~val_b, rc);
                        ppc_cvt_pkg::XO_OR:   res = write_res(ra, val_a | val_b, rc);
                        ppc_cvt_pkg::XO_NAND: res = write_res(ra, ~(val_a & val_b), rc);
                        default:              res = '0;
                    endcase
                end else if (known_mask[rs]) begin
                    res = one_known(sub, ra, rc, val_a, 1'b0);
                end else if (known_mask[rb]) begin
                    res = one_known(sub, ra, rc, val_b, 1'b1);
                end else if (rs == rb) begin
                    res = same_regs(sub, ra, rc);
                end
            end
            default: res = '0;
        endcase
    end

    assign result = res;

endmodule

// File: hdl/ppc_constant_value_tracker.sv
// Top level of the constant-value tracker: input register, register-file memory,
// known mask, fold logic and result register. Depends on ppc_cvt_pkg, ppc_cvt_ram, ppc_cvt_fold.
//
//  Channel | Ports                               | Contents
//  --------+-------------------------------------+-------------------------------------------
//  input   | s_tvalid s_tready s_tdata s_tuser   | one instruction request and its flags
//  result  | m_tvalid m_tready m_tdata           | one fold result per instruction
//
// Each request waits in the input register, where the register values read
// from the memory arrive, and is folded into the result register once that register is free.
// A request can be taken every cycle while results are taken; m_tvalid rises once it is folded.
// A value written by one request is forwarded to the request accepted at the same edge.
// After reset all registers are unknown; the register values need no clearing.
// When the result is not taken, the input register holds and s_tready falls once it is full.
module ppc_constant_value_tracker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [31:0] instr_word, [63:32] gprs_out_mask
    input  logic [ppc_cvt_pkg::S_TDATA_W-1:0]  s_tdata,
    // [0] d_form_flag, [1] sets_carry_flag, [2] sets_overflow_flag
    input  logic [ppc_cvt_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [0] fully_executed, [1] writes_reg, [6:2] dest_reg, [38:7] dest_value,
    // [39] compute_rc, [40] carry_valid, [41] carry_out, [42] overflow_valid,
    // [43] overflow_out, [47:44] zero
    output logic [ppc_cvt_pkg::M_TDATA_W-1:0]  m_tdata
);

    logic                                in_valid_reg;
    logic                                in_valid_next;
    logic [31:0]                         instr_reg;
    logic [31:0]                         gout_reg;
    logic [ppc_cvt_pkg::S_TUSER_W-1:0]   flags_reg;
    logic                                hit_a_reg;
    logic                                hit_b_reg;
    logic [ppc_cvt_pkg::GPR_W-1:0]       fwd_reg;
    logic [ppc_cvt_pkg::NUM_GPRS-1:0]    known_reg;
    logic [ppc_cvt_pkg::NUM_GPRS-1:0]    known_next;
    logic                                out_valid_reg;
    logic                                out_valid_next;
    ppc_cvt_pkg::fold_t                  out_reg;

    logic                                accept;
    logic                                advance;
    logic [5:0]                          s_op;
    logic [ppc_cvt_pkg::GPR_IDX_W-1:0]   rd_addr_a;
    logic [ppc_cvt_pkg::GPR_IDX_W-1:0]   rd_addr_b;
    logic [ppc_cvt_pkg::GPR_W-1:0]       ram_a;
    logic [ppc_cvt_pkg::GPR_W-1:0]       ram_b;
    logic [ppc_cvt_pkg::GPR_W-1:0]       val_a;
    logic [ppc_cvt_pkg::GPR_W-1:0]       val_b;
    logic                                wr_en;
    ppc_cvt_pkg::fold_t                  fold;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // The add forms read RA and RB, all others read RS and RB.
    assign s_op      = s_tdata[31:26];
    assign rd_addr_a = (s_op == ppc_cvt_pkg::OP_ADDI || s_op == ppc_cvt_pkg::OP_ADDIS ||
                        (s_op == ppc_cvt_pkg::OP_EXT && s_tuser[0])) ?
                       s_tdata[20:16] : s_tdata[25:21];
    assign rd_addr_b = s_tdata[15:11];

    assign wr_en = advance && fold.wr;

    ppc_cvt_ram #(
        .WIDTH (ppc_cvt_pkg::GPR_W),
        .DEPTH (ppc_cvt_pkg::NUM_GPRS)
    ) u_regs (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (fold.rd),
        .wr_data   (fold.val),
        .rd_en     (accept),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (ram_a),
        .rd_data_b (ram_b)
    );

    assign val_a = hit_a_reg ? fwd_reg : ram_a;
    assign val_b = hit_b_reg ? fwd_reg : ram_b;

    ppc_cvt_fold u_fold (
        .instr_word         (instr_reg),
        .d_form_flag        (flags_reg[0]),
        .sets_carry_flag    (flags_reg[1]),
        .sets_overflow_flag (flags_reg[2]),
        .known_mask         (known_reg),
        .val_a              (val_a),
        .val_b              (val_b),
        .result             (fold)
    );

    always_comb begin
        in_valid_next  = accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
        known_next     = known_reg;
        if (advance) begin
            if (!fold.done) begin
                known_next = known_next & ~gout_reg;
            end
            if (fold.wr) begin
                known_next[fold.rd] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            known_reg     <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            known_reg     <= known_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            instr_reg <= s_tdata[31:0];
            gout_reg  <= s_tdata[63:32];
            flags_reg <= s_tuser;
            hit_a_reg <= wr_en && (fold.rd == rd_addr_a);
            hit_b_reg <= wr_en && (fold.rd == rd_addr_b);
            fwd_reg   <= fold.val;
        end
        if (advance) begin
            out_reg <= fold;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_reg.ov, out_reg.ovv, out_reg.ca, out_reg.cav, out_reg.rc,
                       out_reg.val, out_reg.rd, out_reg.wr, out_reg.done};

endmodule

// File: test/tb_ppc_constant_value_tracker.sv
`timescale 1ns / 100ps
// Self-checking testbench for ppc_constant_value_tracker: instruction requests in, fold results out.
// Keeps its own copy of the known-register state and checks every result in order.
// Depends on ppc_cvt_pkg and the block's top level.
module tb_ppc_constant_value_tracker;

    localparam int N_RANDOM   = 1075;
    localparam int IDLE_LIMIT = 2000;
    localparam int TAIL_CYC   = 8;

    localparam logic [2:0] FL_DFORM = 3'b001;
    localparam logic [2:0] FL_CARRY = 3'b010;
    localparam logic [2:0] FL_OVF   = 3'b100;

    localparam logic [9:0] ADD_XOS [4] = '{ppc_cvt_pkg::XO_ADDC, ppc_cvt_pkg::XO_ADD,
                                           ppc_cvt_pkg::XO_ADDCO, ppc_cvt_pkg::XO_ADDO};
    localparam logic [9:0] LOGIC_XOS [8] = '{ppc_cvt_pkg::XO_AND, ppc_cvt_pkg::XO_ANDC,
                                             ppc_cvt_pkg::XO_NOR, ppc_cvt_pkg::XO_EQV,
                                             ppc_cvt_pkg::XO_XOR, ppc_cvt_pkg::XO_ORC,
                                             ppc_cvt_pkg::XO_OR, ppc_cvt_pkg::XO_NAND};

    typedef struct {
        logic [31:0] word;
        logic [31:0] mask;
        logic [2:0]  flags;
    } instr_req_t;

    logic                               aclk = 1'b0;
    logic                               aresetn = 1'b0;
    logic                               s_tvalid = 1'b0;
    logic                               s_tready;
    logic [ppc_cvt_pkg::S_TDATA_W-1:0]  s_tdata = '0;
    logic [ppc_cvt_pkg::S_TUSER_W-1:0]  s_tuser = '0;
    logic                               m_tvalid;
    logic                               m_tready = 1'b0;
    logic [ppc_cvt_pkg::M_TDATA_W-1:0]  m_tdata;

    instr_req_t          pend_reqs [$];
    ppc_cvt_pkg::fold_t  exp_folds [$];
    logic [31:0]         gpr_val [32];
    logic [31:0]         gpr_known = '0;
    int                  req_total = 1;
    int                  sent_cnt = 0;
    int                  rcv_cnt = 0;
    int                  fail_cnt = 0;
    int                  idle_cycles = 0;

    ppc_constant_value_tracker u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic logic [31:0] enc_d(input logic [5:0] op, input logic [4:0] rt,
                                          input logic [4:0] ra, input logic [15:0] imm);
        return {op, rt, ra, imm};
    endfunction

    function automatic logic [31:0] enc_x(input logic [4:0] rs, input logic [4:0] ra,
                                          input logic [4:0] rb, input logic [9:0] xo,
                                          input logic rc);
        return {ppc_cvt_pkg::OP_EXT, rs, ra, rb, xo, rc};
    endfunction

    function automatic logic [4:0] pick_reg();
        return ($urandom_range(0, 1) == 0) ? 5'($urandom_range(0, 3)) : 5'($urandom_range(0, 31));
    endfunction

    function automatic ppc_cvt_pkg::fold_t fold_write(input logic [4:0] rd,
                                                      input logic [31:0] val,
                                                      input logic rc);
        ppc_cvt_pkg::fold_t f;
        f = '0;
        f.done = 1'b1;
        f.wr = 1'b1;
        f.rd = rd;
        f.val = val;
        f.rc = rc;
        return f;
    endfunction

    function automatic int idle_pct(input int cnt, input bit sender);
        if (cnt < req_total / 3) begin
            return sender ? 14 : 83;
        end else if (cnt < (2 * req_total) / 3) begin
            return sender ? 83 : 14;
        end
        return 0;
    endfunction

    task automatic add_req(input logic [31:0] word, input logic [2:0] flags,
                           input logic [31:0] mask);
        instr_req_t r;
        r.word = word;
        r.flags = flags;
        r.mask = mask;
        pend_reqs.push_back(r);
    endtask

    // Folds one accepted request against the tracked state, updates that state and
    // queues the expected result.
    task automatic track_instr(input logic [31:0] w, input logic [2:0] flags,
                               input logic [31:0] mask);
        ppc_cvt_pkg::fold_t f;
        logic [5:0]  op;
        logic [4:0]  rs, ra, rb;
        logic [15:0] imm;
        logic [9:0]  xo;
        logic        rc, hs, hb;
        logic [31:0] k, a, b, d, v, vi;
        f = '0;
        op = w[31:26];
        rs = w[25:21];
        ra = w[20:16];
        rb = w[15:11];
        imm = w[15:0];
        xo = w[10:1];
        rc = w[0];
        if (op == ppc_cvt_pkg::OP_ADDI || op == ppc_cvt_pkg::OP_ADDIS) begin
            k = (op == ppc_cvt_pkg::OP_ADDIS) ? {imm, 16'h0000} : {{16{imm[15]}}, imm};
            if (ra == 5'd0) begin
                f = fold_write(rs, k, 1'b0);
            end else if (gpr_known[ra]) begin
                f = fold_write(rs, gpr_val[ra] + k, 1'b0);
            end
        end else if (op >= ppc_cvt_pkg::OP_ORI && op <= ppc_cvt_pkg::OP_ANDIS) begin
            k = op[0] ? {imm, 16'h0000} : {16'h0000, imm};
            if (imm == 16'h0000 && op != ppc_cvt_pkg::OP_ANDI &&
                op != ppc_cvt_pkg::OP_ANDIS && ra == rs) begin
                f.done = 1'b1;
            end else if (gpr_known[rs]) begin
                case (op)
                    ppc_cvt_pkg::OP_ORI, ppc_cvt_pkg::OP_ORIS: begin
                        f = fold_write(ra, gpr_val[rs] | k, 1'b0);
                    end
                    ppc_cvt_pkg::OP_XORI, ppc_cvt_pkg::OP_XORIS: begin
                        f = fold_write(ra, gpr_val[rs] ^ k, 1'b0);
                    end
                    default: begin
                        f = fold_write(ra, gpr_val[rs] & k, 1'b1);
                    end
                endcase
            end
        end else if (op == ppc_cvt_pkg::OP_EXT) begin
            if (flags[0]) begin
                if (gpr_known[ra] && gpr_known[rb] &&
                    (xo == ppc_cvt_pkg::XO_ADDC || xo == ppc_cvt_pkg::XO_ADDCO ||
                     xo == ppc_cvt_pkg::XO_ADD || xo == ppc_cvt_pkg::XO_ADDO)) begin
                    a = gpr_val[ra];
                    b = gpr_val[rb];
                    d = a + b;
                    f = fold_write(rs, d, rc);
                    if (flags[1]) begin
                        f.cav = 1'b1;
                        f.ca = (d < a);
                    end
                    if (flags[2]) begin
                        f.ovv = 1'b1;
                        f.ov = ~(a[31] ^ b[31]) & (a[31] ^ d[31]);
                    end
                end
            end else begin
                hs = gpr_known[rs];
                hb = gpr_known[rb];
                if (hs && hb) begin
                    a = gpr_val[rs];
                    b = gpr_val[rb];
                    case (xo)
                        ppc_cvt_pkg::XO_AND:  f = fold_write(ra, a & b, rc);
                        ppc_cvt_pkg::XO_ANDC: f = fold_write(ra, a & ~b, rc);
                        ppc_cvt_pkg::XO_NOR:  f = fold_write(ra, ~(a | b), rc);
                        ppc_cvt_pkg::XO_EQV:  f = fold_write(ra, ~(a ^ b), rc);
                        ppc_cvt_pkg::XO_XOR:  f = fold_write(ra, a ^ b, rc);
                        ppc_cvt_pkg::XO_ORC:  f = fold_write(ra, a | ~b, rc);
                        ppc_cvt_pkg::XO_OR:   f = fold_write(ra, a | b, rc);
                        ppc_cvt_pkg::XO_NAND: f = fold_write(ra, ~(a & b), rc);
                        default:              f = '0;
                    endcase
                end else if (hs || hb) begin
                    // With only RB known, andc and orc see the complement of its value.
                    v = hs ? gpr_val[rs] : gpr_val[rb];
                    vi = hs ? v : ~v;
                    case (xo)
                        ppc_cvt_pkg::XO_ANDC: if (vi == 32'h0) f = fold_write(ra, 32'h0, rc);
                        ppc_cvt_pkg::XO_AND:  if (v == 32'h0) f = fold_write(ra, 32'h0, rc);
                        ppc_cvt_pkg::XO_NOR: begin
                            if (v == ppc_cvt_pkg::ALL_ONES) f = fold_write(ra, 32'h0, rc);
                        end
                        ppc_cvt_pkg::XO_ORC: begin
                            if (vi == ppc_cvt_pkg::ALL_ONES) begin
                                f = fold_write(ra, ppc_cvt_pkg::ALL_ONES, rc);
                            end
                        end
                        ppc_cvt_pkg::XO_OR: begin
                            if (v == ppc_cvt_pkg::ALL_ONES) begin
                                f = fold_write(ra, ppc_cvt_pkg::ALL_ONES, rc);
                            end
                        end
                        ppc_cvt_pkg::XO_NAND: begin
                            if (v == 32'h0) f = fold_write(ra, ppc_cvt_pkg::ALL_ONES, rc);
                        end
                        default: f = '0;
                    endcase
                end else if (rs == rb) begin
                    case (xo)
                        ppc_cvt_pkg::XO_ANDC: f = fold_write(ra, 32'h0, rc);
                        ppc_cvt_pkg::XO_EQV:  f = fold_write(ra, ppc_cvt_pkg::ALL_ONES, rc);
                        ppc_cvt_pkg::XO_XOR:  f = fold_write(ra, 32'h0, rc);
                        ppc_cvt_pkg::XO_ORC:  f = fold_write(ra, ppc_cvt_pkg::ALL_ONES, rc);
                        default:              f = '0;
                    endcase
                end
            end
        end
        if (!f.done) begin
            gpr_known = gpr_known & ~mask;
        end
        if (f.wr) begin
            gpr_val[f.rd] = f.val;
            gpr_known[f.rd] = 1'b1;
        end
        exp_folds.push_back(f);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            fail_cnt++;
        end
    endtask

    // Driver: presents pending requests and records each accepted one.
    always @(posedge aclk) begin : drv
        instr_req_t req;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                track_instr(s_tdata[31:0], s_tuser, s_tdata[63:32]);
                sent_cnt++;
            end
            if (!s_tvalid || s_tready) begin
                if (pend_reqs.size() > 0 && $urandom_range(0, 99) >= idle_pct(sent_cnt, 1'b1)) begin
                    req = pend_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {req.mask, req.word};
                    s_tuser <= req.flags;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compares each accepted result with the oldest expected fold.
    always @(posedge aclk) begin : mon
        ppc_cvt_pkg::fold_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (exp_folds.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual %h", $time, m_tdata);
                    fail_cnt++;
                end else begin
                    want = exp_folds.pop_front();
                    check_field("fully_executed", want.done, m_tdata[0]);
                    check_field("writes_reg", want.wr, m_tdata[1]);
                    check_field("dest_reg", want.rd, m_tdata[6:2]);
                    check_field("dest_value", want.val, m_tdata[38:7]);
                    check_field("compute_rc", want.rc, m_tdata[39]);
                    check_field("carry_valid", want.cav, m_tdata[40]);
                    check_field("carry_out", want.ca, m_tdata[41]);
                    check_field("overflow_valid", want.ovv, m_tdata[42]);
                    check_field("overflow_out", want.ov, m_tdata[43]);
                    check_field("pad", 32'h0, m_tdata[47:44]);
                end
                rcv_cnt++;
            end
            m_tready <= ($urandom_range(0, 99) >= idle_pct(rcv_cnt, 1'b0));
        end
    end

    // Watchdog on cycles in which neither channel moves a request.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin : stim
        int          kind;
        int          pick;
        logic [5:0]  op;
        logic [4:0]  rt, ra, rb, dst;
        logic [15:0] imm;
        logic [9:0]  xo;
        logic [31:0] word, mask;
        logic [2:0]  flags;
        for (int i = 0; i < 32; i++) begin
            gpr_val[i] = '0;
        end

        // Directed part: constants from r0, register-relative adds, no-op immediates,
        // the add family with carry and overflow, the one-known shortcuts, the
        // same-register cases, a full logical fold and an unhandled opcode.
        add_req(enc_d(ppc_cvt_pkg::OP_ADDI, 5'd3, 5'd0, 16'h0000), 3'b000, 32'd1 << 3);
        add_req(enc_d(ppc_cvt_pkg::OP_ADDI, 5'd4, 5'd0, 16'hFFFF), 3'b000, 32'd1 << 4);
        add_req(enc_d(ppc_cvt_pkg::OP_ADDIS, 5'd5, 5'd0, 16'h8000), 3'b000, 32'd1 << 5);
        add_req(enc_d(ppc_cvt_pkg::OP_ADDI, 5'd6, 5'd5, 16'h7FFF), 3'b000, 32'd1 << 6);
        add_req(enc_d(ppc_cvt_pkg::OP_ADDI, 5'd7, 5'd9, 16'h0001), 3'b000, 32'd1 << 7);
        add_req(enc_d(ppc_cvt_pkg::OP_ORI, 5'd5, 5'd5, 16'h0000), 3'b000, 32'd1 << 5);
        add_req(enc_d(ppc_cvt_pkg::OP_XORIS, 5'd8, 5'd8, 16'h0000), 3'b000, 32'd1 << 8);
        add_req(enc_d(ppc_cvt_pkg::OP_ORI, 5'd4, 5'd10, 16'h1234), 3'b000, 32'd1 << 10);
        add_req(enc_d(ppc_cvt_pkg::OP_XORI, 5'd5, 5'd11, 16'hFFFF), 3'b000, 32'd1 << 11);
        add_req(enc_d(ppc_cvt_pkg::OP_ANDI, 5'd4, 5'd12, 16'h8001), 3'b000, 32'd1 << 12);
        add_req(enc_d(ppc_cvt_pkg::OP_ANDIS, 5'd4, 5'd13, 16'h0000), 3'b000, 32'd1 << 13);
        add_req(enc_x(5'd14, 5'd4, 5'd4, ppc_cvt_pkg::XO_ADDC, 1'b0),
                FL_DFORM | FL_CARRY | FL_OVF, 32'd1 << 14);
        add_req(enc_x(5'd15, 5'd5, 5'd5, ppc_cvt_pkg::XO_ADDCO, 1'b0),
                FL_DFORM | FL_CARRY | FL_OVF, 32'd1 << 15);
        add_req(enc_x(5'd16, 5'd3, 5'd6, ppc_cvt_pkg::XO_ADD, 1'b1), FL_DFORM, 32'd1 << 16);
        add_req(enc_x(5'd17, 5'd6, 5'd6, ppc_cvt_pkg::XO_ADDO, 1'b0), FL_DFORM | FL_OVF,
                32'd1 << 17);
        add_req(enc_x(5'd20, 5'd18, 5'd3, ppc_cvt_pkg::XO_AND, 1'b0), 3'b000, 32'd1 << 18);
        add_req(enc_x(5'd21, 5'd19, 5'd4, ppc_cvt_pkg::XO_ANDC, 1'b1), 3'b000, 32'd1 << 19);
        add_req(enc_x(5'd4, 5'd29, 5'd22, ppc_cvt_pkg::XO_NOR, 1'b0), 3'b000, 32'd1 << 29);
        add_req(enc_x(5'd23, 5'd30, 5'd3, ppc_cvt_pkg::XO_ORC, 1'b0), 3'b000, 32'd1 << 30);
        add_req(enc_x(5'd24, 5'd31, 5'd4, ppc_cvt_pkg::XO_OR, 1'b1), 3'b000, 32'd1 << 31);
        add_req(enc_x(5'd3, 5'd28, 5'd25, ppc_cvt_pkg::XO_NAND, 1'b0), 3'b000, 32'd1 << 28);
        add_req(enc_x(5'd26, 5'd10, 5'd26, ppc_cvt_pkg::XO_EQV, 1'b0), 3'b000, 32'd1 << 10);
        add_req(enc_x(5'd27, 5'd11, 5'd27, ppc_cvt_pkg::XO_XOR, 1'b1), 3'b000, 32'd1 << 11);
        add_req(enc_x(5'd4, 5'd12, 5'd5, ppc_cvt_pkg::XO_XOR, 1'b0), 3'b000, 32'd1 << 12);
        add_req(32'h0000_0000, 3'b111, ppc_cvt_pkg::ALL_ONES);

        // Random part: mostly well-formed folds over a small register subset, with
        // some raw words and random write masks that knock registers out of the known set.
        for (int n = 0; n < N_RANDOM; n++) begin
            kind = $urandom_range(0, 99);
            rt = pick_reg();
            ra = pick_reg();
            rb = pick_reg();
            flags = 3'($urandom_range(0, 7));
            pick = $urandom_range(0, 99);
            imm = (pick < 25) ? 16'h0000 : (pick < 40) ? 16'hFFFF :
                  (pick < 50) ? 16'h8000 : 16'($urandom);
            if (kind < 20) begin
                op = ($urandom_range(0, 1) == 0) ? ppc_cvt_pkg::OP_ADDI : ppc_cvt_pkg::OP_ADDIS;
                if ($urandom_range(0, 9) < 4) begin
                    ra = 5'd0;
                end
                word = enc_d(op, rt, ra, imm);
                dst = rt;
            end else if (kind < 45) begin
                op = ppc_cvt_pkg::OP_ORI + 6'($urandom_range(0, 5));
                if ($urandom_range(0, 9) < 2) begin
                    ra = rt;
                end
                word = enc_d(op, rt, ra, imm);
                dst = ra;
            end else if (kind < 65) begin
                xo = ADD_XOS[2'($urandom_range(0, 3))];
                if ($urandom_range(0, 9) == 0) begin
                    xo = 10'($urandom);
                end
                flags = flags | FL_DFORM;
                word = enc_x(rt, ra, rb, xo, 1'($urandom_range(0, 1)));
                dst = rt;
            end else if (kind < 90) begin
                xo = LOGIC_XOS[3'($urandom_range(0, 7))];
                if ($urandom_range(0, 9) == 0) begin
                    xo = 10'($urandom);
                end
                if ($urandom_range(0, 3) == 0) begin
                    rb = rt;
                end
                flags = flags & ~FL_DFORM;
                word = enc_x(rt, ra, rb, xo, 1'($urandom_range(0, 1)));
                dst = ra;
            end else begin
                word = $urandom;
                dst = word[20:16];
            end
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                mask = 32'd1 << dst;
            end else if (pick < 8) begin
                mask = (32'd1 << dst) | $urandom;
            end else begin
                mask = $urandom;
            end
            add_req(word, flags, mask);
        end
        req_total = pend_reqs.size();

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        while (pend_reqs.size() != 0 || s_tvalid || exp_folds.size() != 0) begin
            @(negedge aclk);
        end
        repeat (TAIL_CYC) @(posedge aclk);

        if (fail_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
